// ===== rtl/ksh_pkg.sv =====
// Shared types and constants for the keyed SipHash byte hash.
// Used by the front, queue, back and top level; depends on nothing.
package ksh_pkg;

	typedef enum logic [1:0] {
		K_MID,
		K_LAST,
		K_MIX4,
		K_MIX8
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        start;
		logic        full;
		logic [63:0] word;
		logic [63:0] block;
		logic [63:0] seed;
	} entry_t;

	typedef logic [3:0][63:0] sip_state_t;

	localparam logic [63:0] SEED_RESET = 64'h7071067811865475;
	localparam logic [63:0] IV0        = 64'h736f6d6570736575;
	localparam logic [63:0] IV1        = 64'h646f72616e646f6d;
	localparam logic [63:0] IV2        = 64'h6c7967656e657261;
	localparam logic [63:0] IV3        = 64'h7465646279746573;

	localparam logic [3:0]  FULL_BYTES = 4'd8;
	localparam logic [3:0]  MIX4_BYTES = 4'd4;
	localparam logic [7:0]  WORD_BYTES = 8'd8;

	localparam logic [31:0] MIX4_ADD   = 32'd61;
	localparam logic [31:0] MIX4_MUL   = 32'h27d4eb2d;
	localparam logic [63:0] MIX8_MUL_A = 64'd265;
	localparam logic [63:0] MIX8_MUL_B = 64'd21;
	localparam logic [63:0] FIN_XOR    = 64'hff;

endpackage

// ===== rtl/ksh_ifs.sv =====
// Handshake channels of the keyed SipHash byte hash: key words in, hashes out.
// No dependencies.
interface ksh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last_word;

	modport source(output valid, data_word, byte_count, last_word, input ready);
	modport sink(input valid, data_word, byte_count, last_word, output ready);
endinterface

interface ksh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source(output valid, hash_value, input ready);
	modport sink(input valid, hash_value, output ready);
endinterface

// ===== rtl/ksh_front.sv =====
// Front end: seed register, key tracking, classification of each word.
// Builds the length block and pushes one queue entry per item; uses ksh_pkg, ksh_in_if.
module ksh_front (
	input  logic             clk,
	input  logic             arst_n,
	ksh_in_if.sink           words,
	input  logic             cfg_we,
	input  logic [63:0]      cfg_wdata,
	input  logic             q_full,
	output logic             q_push,
	output ksh_pkg::entry_t  q_entry
);

	logic [63:0] seed_q;
	logic        start_q;
	logic [7:0]  len_q;

	logic [3:0]  cnt;
	logic [7:0]  len_base;
	logic [7:0]  len_new;
	logic [55:0] tail;

	assign words.ready = !q_full;
	assign q_push      = words.valid && !q_full;

	always_comb begin
		cnt      = (words.byte_count > ksh_pkg::FULL_BYTES) ? ksh_pkg::FULL_BYTES
			: words.byte_count;
		len_base = start_q ? 8'd0 : len_q;
		len_new  = words.last_word ? len_base + {4'd0, cnt} : len_base + ksh_pkg::WORD_BYTES;
		// keep only the valid tail bytes below the length byte
		for (int i = 0; i < 7; i++) begin
			tail[i*8 +: 8] = (4'(i) < cnt) ? words.data_word[i*8 +: 8] : 8'd0;
		end

		q_entry.start = start_q;
		q_entry.full  = (cnt == ksh_pkg::FULL_BYTES);
		q_entry.word  = words.data_word;
		q_entry.block = {len_new, q_entry.full ? 56'd0 : tail};
		q_entry.seed  = seed_q;
		if (!words.last_word) begin
			q_entry.kind = ksh_pkg::K_MID;
		end else if (start_q && cnt == ksh_pkg::MIX4_BYTES) begin
			q_entry.kind = ksh_pkg::K_MIX4;
		end else if (start_q && cnt == ksh_pkg::FULL_BYTES) begin
			q_entry.kind = ksh_pkg::K_MIX8;
		end else begin
			q_entry.kind = ksh_pkg::K_LAST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= ksh_pkg::SEED_RESET;
			start_q <= 1'b1;
			len_q   <= 8'd0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (q_push) begin
				start_q <= words.last_word;
				len_q   <= words.last_word ? 8'd0 : len_new;
			end
		end
	end

endmodule

// ===== rtl/ksh_queue.sv =====
// Short queue of classified items between the front and the back.
// Uses ksh_pkg.
module ksh_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ksh_pkg::entry_t  entry_in,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output ksh_pkg::entry_t  head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ksh_pkg::entry_t    slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ksh_back.sv =====
// Back end: SipHash round unit, finalisation, short-key mixes, output register.
// One queue step per cycle, a final step held on a full output; uses ksh_pkg, ksh_out_if.
module ksh_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  ksh_pkg::entry_t  head,
	output logic             q_pop,
	ksh_out_if.source        hashes
);

	typedef enum logic [2:0] {
		B_RUN,
		B_BLOCK,
		B_FIN,
		B_MIX2,
		B_MIX3
	} bstate_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic ksh_pkg::sip_state_t sip_round(input ksh_pkg::sip_state_t v);
		ksh_pkg::sip_state_t w;
		w = v;
		w[0] = w[0] + w[1]; w[1] = rotl(w[1], 13); w[1] = w[1] ^ w[0]; w[0] = rotl(w[0], 32);
		w[2] = w[2] + w[3]; w[3] = rotl(w[3], 16); w[3] = w[3] ^ w[2];
		w[0] = w[0] + w[3]; w[3] = rotl(w[3], 21); w[3] = w[3] ^ w[0];
		w[2] = w[2] + w[1]; w[1] = rotl(w[1], 17); w[1] = w[1] ^ w[2]; w[2] = rotl(w[2], 32);
		return w;
	endfunction

	function automatic ksh_pkg::sip_state_t absorb(input ksh_pkg::sip_state_t v,
		input logic [63:0] m);
		ksh_pkg::sip_state_t w;
		w    = v;
		w[3] = w[3] ^ m;
		w    = sip_round(w);
		w[0] = w[0] ^ m;
		return w;
	endfunction

	function automatic logic [63:0] non_zero(input logic [63:0] h);
		return (h == 64'd0) ? 64'd1 : h;
	endfunction

	bstate_t             state_q;
	ksh_pkg::sip_state_t v_q;
	logic [63:0]         mix_q;
	logic                hash_valid_q;
	logic [63:0]         hash_q;

	ksh_pkg::sip_state_t vin;
	ksh_pkg::sip_state_t vfin;
	logic [63:0]         fin_hash;
	logic                out_free;
	logic                emit;
	logic [31:0]         m4_a, m4_b, m4_c, m4_d, m4_p;
	logic [31:0]         g0, g1;
	logic [63:0]         res4;
	logic [63:0]         a0, a1, a2, a3;
	logic [63:0]         b1, b2, b3;
	logic [63:0]         c1, c2, c3;

	assign hashes.valid      = hash_valid_q;
	assign hashes.hash_value = hash_q;
	assign out_free          = !hash_valid_q || hashes.ready;
	// a final step loads a new hash into the output register
	assign emit              = q_pop && (state_q != B_RUN);

	always_comb begin
		// a new key starts from the state loaded from its seed
		if (head.start) begin
			vin[0] = ksh_pkg::IV0 ^ head.seed;
			vin[1] = ksh_pkg::IV1 ^ ~head.seed;
			vin[2] = ksh_pkg::IV2 ^ head.seed;
			vin[3] = ksh_pkg::IV3 ^ ~head.seed;
		end else begin
			vin = v_q;
		end

		vfin     = v_q;
		vfin[2]  = vfin[2] ^ ksh_pkg::FIN_XOR;
		vfin     = sip_round(vfin);
		fin_hash = vfin[1] ^ vfin[2] ^ vfin[3];

		// four-byte mix: first half up to the multiply, second half from its register
		m4_a = head.word[31:0] ^ head.seed[31:0];
		m4_b = (m4_a ^ ksh_pkg::MIX4_ADD) ^ (m4_a >> 16);
		m4_c = m4_b + (m4_b << 3);
		m4_d = m4_c ^ (m4_c >> 4);
		m4_p = m4_d * ksh_pkg::MIX4_MUL;
		g0   = mix_q[31:0] ^ head.seed[31:0];
		g1   = g0 ^ (g0 >> 15);
		res4 = {g1, g1} ^ head.seed;

		// eight-byte mix, three stages split at the multiplies
		a0 = head.word ^ head.seed;
		a1 = ~a0 + (a0 << 21);
		a2 = a1 ^ rotl(a1, 40);
		a3 = a2 * ksh_pkg::MIX8_MUL_A;
		b1 = mix_q ^ rotl(mix_q, 50);
		b2 = b1 ^ head.seed;
		b3 = b2 * ksh_pkg::MIX8_MUL_B;
		c1 = mix_q ^ rotl(mix_q, 36);
		c2 = c1 + (c1 << 31);
		c3 = ~c2 + (c2 << 18);
	end

	always_comb begin
		case (state_q)
			B_RUN:   q_pop = q_valid && head.kind == ksh_pkg::K_MID;
			B_FIN:   q_pop = out_free;
			B_MIX2:  q_pop = out_free && head.kind == ksh_pkg::K_MIX4;
			B_MIX3:  q_pop = out_free;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_RUN;
			v_q          <= '0;
			mix_q        <= '0;
			hash_valid_q <= 1'b0;
			hash_q       <= '0;
		end else begin
			if (hash_valid_q && hashes.ready && !emit) begin
				hash_valid_q <= 1'b0;
			end
			case (state_q)
				B_RUN: begin
					if (q_valid) begin
						case (head.kind)
							ksh_pkg::K_MID: begin
								v_q <= absorb(vin, head.word);
							end
							ksh_pkg::K_LAST: begin
								if (head.full) begin
									v_q     <= absorb(vin, head.word);
									state_q <= B_BLOCK;
								end else begin
									v_q     <= absorb(vin, head.block);
									state_q <= B_FIN;
								end
							end
							ksh_pkg::K_MIX4: begin
								mix_q   <= {32'd0, m4_p};
								state_q <= B_MIX2;
							end
							ksh_pkg::K_MIX8: begin
								mix_q   <= a3;
								state_q <= B_MIX2;
							end
							default: begin
								state_q <= B_RUN;
							end
						endcase
					end
				end
				B_BLOCK: begin
					v_q     <= absorb(v_q, head.block);
					state_q <= B_FIN;
				end
				B_FIN: begin
					if (out_free) begin
						hash_q       <= non_zero(fin_hash);
						hash_valid_q <= 1'b1;
						state_q      <= B_RUN;
					end
				end
				B_MIX2: begin
					if (head.kind == ksh_pkg::K_MIX4) begin
						if (out_free) begin
							hash_q       <= non_zero(res4);
							hash_valid_q <= 1'b1;
							state_q      <= B_RUN;
						end
					end else begin
						mix_q   <= b3;
						state_q <= B_MIX3;
					end
				end
				B_MIX3: begin
					if (out_free) begin
						hash_q       <= non_zero(c3);
						hash_valid_q <= 1'b1;
						state_q      <= B_RUN;
					end
				end
				default: begin
					state_q <= B_RUN;
				end
			endcase
		end
	end

endmodule

// ===== rtl/keyed_siphash_byte_hash.sv =====
// Top level of the keyed SipHash byte hash: front, queue and back joined.
// Uses ksh_pkg, ksh_ifs, ksh_front, ksh_queue, ksh_back.
//
//   channel   dir  handshake      payload
//   words     in   valid/ready    data_word[63:0], byte_count[3:0], last_word
//   hashes    out  valid/ready    hash_value[63:0]
//   cfg       in   cfg_we         cfg_wdata[63:0] -> seed
//
// A middle word is absorbed by the round unit directly. A short last word takes
// the block round and then the final round, a full last word its own round first;
// a lone key of 4 or 8 bytes is split at the register after each multiply.
// Reset loads the default seed and starts a new key; no clearing pass.
// The queue of QDEPTH entries lets words enter while the back is busy or the
// output register waits on hashes.ready.
module keyed_siphash_byte_hash #(
	parameter int QDEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	ksh_in_if.sink      words,
	ksh_out_if.source   hashes,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	ksh_pkg::entry_t  q_entry;
	ksh_pkg::entry_t  q_head;

	ksh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.words     (words),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	ksh_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.entry_in (q_entry),
		.pop      (q_pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head)
	);

	ksh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (q_head),
		.q_pop   (q_pop),
		.hashes  (hashes)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_hash_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		hashes.valid |-> hashes.hash_value != 64'd0)
		else $error("zero hash presented");

	a_pop_once: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.kind != ksh_pkg::K_MID) |=> !$past(hashes.valid && !hashes.ready)
		|| hashes.valid)
		else $error("result lost on final step");

endmodule

// ===== sim/tb_keyed_siphash_byte_hash.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keyed_siphash_byte_hash: random and directed keys,
// checked against a scoreboard holding its own SipHash-1-1 predictor.
// Depends on the ksh_in_if / ksh_out_if interfaces and the block itself.
module tb_keyed_siphash_byte_hash;

	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE_CYC  = 24;
	localparam int GAP_PERCENT = 19;

	class hash_scoreboard;
		localparam logic [63:0] POWER_ON_SEED = 64'h7071067811865475;
		localparam logic [63:0] INIT_A = 64'h736f6d6570736575;
		localparam logic [63:0] INIT_B = 64'h646f72616e646f6d;
		localparam logic [63:0] INIT_C = 64'h6c7967656e657261;
		localparam logic [63:0] INIT_D = 64'h7465646279746573;
		localparam logic [63:0] LOW32  = 64'hffffffff;
		localparam logic [63:0] FOLD   = 64'h27d4eb2d;
		localparam int unsigned SHORT_KEY = 4;
		localparam int unsigned WORD_LEN  = 8;

		logic [63:0] seed;
		logic [63:0] v [4];
		logic [7:0]  key_len;
		bit          fresh_key;
		logic [63:0] hashes_due [$];
		int          errors;

		function new();
			seed      = POWER_ON_SEED;
			key_len   = 8'd0;
			fresh_key = 1'b1;
			errors    = 0;
			load_state();
		endfunction

		function logic [63:0] rol(logic [63:0] x, int unsigned r);
			return (x << r) | (x >> (64 - r));
		endfunction

		function logic [63:0] ror(logic [63:0] x, int unsigned r);
			return (x >> r) | (x << (64 - r));
		endfunction

		function void load_state();
			v[0] = INIT_A ^ seed;
			v[1] = INIT_B ^ ~seed;
			v[2] = INIT_C ^ seed;
			v[3] = INIT_D ^ ~seed;
		endfunction

		function void sip_round();
			v[0] += v[1]; v[1] = rol(v[1], 13); v[1] ^= v[0]; v[0] = rol(v[0], 32);
			v[2] += v[3]; v[3] = rol(v[3], 16); v[3] ^= v[2];
			v[0] += v[3]; v[3] = rol(v[3], 21); v[3] ^= v[0];
			v[2] += v[1]; v[1] = rol(v[1], 17); v[1] ^= v[2]; v[2] = rol(v[2], 32);
		endfunction

		function void absorb(logic [63:0] m);
			v[3] ^= m;
			sip_round();
			v[0] ^= m;
		endfunction

		function logic [63:0] mix_short(logic [63:0] w);
			logic [63:0] h;
			h = (w ^ seed) & LOW32;
			h = (h ^ 64'd61) ^ (h >> 16);
			h = (h + (h << 3)) & LOW32;
			h = h ^ (h >> 4);
			h = (h * FOLD) & LOW32;
			h ^= seed & LOW32;
			h = h ^ (h >> 15);
			return {h[31:0], h[31:0]} ^ seed;
		endfunction

		function logic [63:0] mix_word(logic [63:0] w);
			logic [63:0] h;
			h = w ^ seed;
			h = ~h + (h << 21);
			h ^= ror(h, 24);
			h *= 64'd265;
			h ^= ror(h, 14);
			h ^= seed;
			h *= 64'd21;
			h ^= ror(h, 28);
			h += h << 31;
			h = ~h + (h << 18);
			return h;
		endfunction

		function void set_seed(logic [63:0] value);
			seed = value;
		endfunction

		function int pending();
			return hashes_due.size();
		endfunction

		// Note an accepted key word; queue the hash it completes, if any.
		function void note_word(logic [63:0] word, logic [3:0] count, logic last);
			int unsigned nb;
			bit          single;
			logic [63:0] h;
			logic [63:0] blk;
			single = fresh_key;
			if (fresh_key) begin
				load_state();
				key_len   = 8'd0;
				fresh_key = 1'b0;
			end
			if (!last) begin
				absorb(word);
				key_len += 8'd8;
				return;
			end
			nb = (count > WORD_LEN) ? WORD_LEN : count;
			fresh_key = 1'b1;
			if (single && nb == SHORT_KEY) begin
				h = mix_short(word);
			end else if (single && nb == WORD_LEN) begin
				h = mix_word(word);
			end else begin
				key_len += nb[7:0];
				if (nb == WORD_LEN) begin
					absorb(word);
					nb = 0;
				end
				blk = {key_len, 56'd0};
				if (nb != 0)
					blk |= word & ((64'd1 << (8 * nb)) - 64'd1);
				absorb(blk);
				v[2] ^= 64'hff;
				sip_round();
				h = v[1] ^ v[2] ^ v[3];
			end
			key_len = 8'd0;
			hashes_due.push_back((h == 64'd0) ? 64'd1 : h);
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		task check_hash(logic [63:0] got);
			logic [63:0] want;
			if (hashes_due.size() == 0) begin
				report($sformatf("hash %h with none due", got));
			end else begin
				want = hashes_due.pop_front();
				if (got !== want)
					report($sformatf("hash_value got %h want %h", got, want));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;
	bit          no_gaps;
	int          idle_cycles = 0;

	hash_scoreboard sb;

	ksh_in_if  key_in();
	ksh_out_if hash_out();

	keyed_siphash_byte_hash u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.words    (key_in),
		.hashes   (hash_out),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Back-pressure on the hash channel.
	always @(negedge clk) begin
		hash_out.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
	end

	always @(posedge clk) begin
		if (arst_n && hash_out.valid && hash_out.ready)
			sb.check_hash(hash_out.hash_value);
	end

	always @(posedge clk) begin
		if ((key_in.valid && key_in.ready) || (hash_out.valid && hash_out.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [63:0] word, input logic [3:0] count, input logic last);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
			key_in.valid <= 1'b0;
			@(negedge clk);
		end
		key_in.valid      <= 1'b1;
		key_in.data_word  <= word;
		key_in.byte_count <= count;
		key_in.last_word  <= last;
		do @(posedge clk); while (!key_in.ready);
		sb.note_word(word, count, last);
	endtask

	// Drop valid, wait for every hash due, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		key_in.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_seed(value);
	endtask

	function automatic logic [63:0] rand_word();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return 64'd0;
		if (pick < 10)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [3:0] rand_tail_count();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) return 4'd4;
		if (pick < 40) return 4'd8;
		if (pick < 50) return 4'd0;
		if (pick < 60) return 4'($urandom_range(9, 15));
		return 4'($urandom_range(0, 8));
	endfunction

	task automatic run_phase(input logic [63:0] new_seed, input int target, input bit steady);
		int sent;
		int mids;
		int pick;
		sent = 0;
		drain();
		write_seed(new_seed);
		no_gaps = steady;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)      mids = 0;
			else if (pick < 85) mids = $urandom_range(1, 4);
			else if (pick < 97) mids = $urandom_range(5, 12);
			else                mids = $urandom_range(30, 40); // length can wrap past 255
			repeat (mids)
				send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
			send_word(rand_word(), rand_tail_count(), 1'b1);
			sent += mids + 1;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		sb                = new();
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 64'd0;
		no_gaps           = 1'b0;
		key_in.valid      = 1'b0;
		key_in.data_word  = 64'd0;
		key_in.byte_count = 4'd0;
		key_in.last_word  = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Lone keys under the power-on seed: integer mixes, empty, saturated, short tail.
		send_word(64'd0, 4'd4, 1'b1);
		send_word('1, 4'd8, 1'b1);
		send_word({$urandom, $urandom}, 4'd0, 1'b1);
		send_word({$urandom, $urandom}, 4'd15, 1'b1);
		send_word('1, 4'd3, 1'b1);
		// Two-word keys: full last word, empty last word, four-byte tail, oversized count.
		send_word({$urandom, $urandom}, 4'd5, 1'b0);
		send_word({$urandom, $urandom}, 4'd8, 1'b1);
		send_word('1, 4'd15, 1'b0);
		send_word({$urandom, $urandom}, 4'd0, 1'b1);
		send_word(64'd0, 4'd0, 1'b0);
		send_word({$urandom, $urandom}, 4'd4, 1'b1);
		send_word({$urandom, $urandom}, 4'd8, 1'b0);
		send_word('1, 4'd9, 1'b1);
		// Seed change between the words of one key: keep the state loaded at its start.
		send_word({$urandom, $urandom}, 4'd2, 1'b0);
		drain();
		write_seed({$urandom, $urandom});
		send_word({$urandom, $urandom}, 4'd7, 1'b1);
		send_word({$urandom, $urandom}, 4'd4, 1'b1);

		run_phase(64'd0, 300, 1'b0);
		run_phase('1, 300, 1'b1);
		run_phase({$urandom, $urandom}, 300, 1'b0);
		run_phase({$urandom, $urandom}, 300, 1'b0);
		run_phase(64'h7071067811865475, 300, 1'b0);

		@(negedge clk);
		key_in.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
